/* hw/rtl/u8pdfesc_pkg.sv */
// shared types and constants for the utf-8 to pdf string escaper
package u8pdfesc_pkg;

    // default depth of the queue between decoder and expander
    localparam int U8_FIFO_DEPTH = 4;

    // stored code point bits while a sequence is open (3 + 6 + 6)
    localparam int PART_W = 15;
    // full code point width
    localparam int CP_W   = 21;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_INVALID     = 2'd1,
        ERR_UNSUPPORTED = 2'd2
    } err_t;

    // what the expander emits for one queued entry
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,  // one byte
        OP_ESC  = 2'd1,  // backslash then the byte
        OP_EURO = 2'd2,  // backslash '2' '0' '0'
        OP_MARK = 2'd3   // one result with no byte: error and/or end of text
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        err_t       err;
        logic       eot;
    } desc_t;

    // queue status seen by the decoder and the expander
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_ZERO   = 8'h30;

endpackage

/* hw/rtl/u8pdfesc_front.sv */
// utf-8 decoder and classifier: turns each input byte into at most one queue entry
module u8pdfesc_front
    import u8pdfesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       eot,
    output logic       push,
    output desc_t      desc
);

    logic [PART_W-1:0] part_reg, part_next;
    logic [1:0]        rem_reg, rem_next;
    logic              latch_reg, latch_next;

    logic [CP_W-1:0]   cp;
    logic              have_cp;
    logic              ok;
    err_t              err;
    logic              has_out;
    op_t               enc_op;
    logic [7:0]        enc_data;

    always_comb
    begin
        part_next = part_reg;
        rem_next  = rem_reg;
        latch_next = latch_reg;
        cp        = '0;
        have_cp   = 1'b0;
        ok        = 1'b0;
        err       = ERR_NONE;
        has_out   = 1'b0;
        enc_op    = OP_BYTE;
        enc_data  = 8'h00;
        push      = 1'b0;
        desc      = '{op: OP_MARK, data: 8'h00, err: ERR_NONE, eot: eot};

        if (latch_reg)
        begin
            // swallow bytes until the end of the text
            if (eot)
            begin
                push       = 1'b1;
                part_next  = '0;
                rem_next   = '0;
                latch_next = 1'b0;
            end
        end
        else
        begin
            if (rem_reg == 2'd0)
            begin
                if (in_byte < 8'h80)
                begin
                    cp      = CP_W'(in_byte);
                    have_cp = 1'b1;
                end
                else if (in_byte >= 8'hC2 && in_byte <= 8'hDF)
                begin
                    part_next = PART_W'(in_byte[4:0]);
                    rem_next  = 2'd1;
                end
                else if (in_byte >= 8'hE0 && in_byte <= 8'hEF)
                begin
                    part_next = PART_W'(in_byte[3:0]);
                    rem_next  = 2'd2;
                end
                else if (in_byte >= 8'hF0 && in_byte <= 8'hF4)
                begin
                    part_next = PART_W'(in_byte[2:0]);
                    rem_next  = 2'd3;
                end
                else
                begin
                    err = ERR_INVALID;
                end
            end
            else
            begin
                ok = (in_byte[7:6] == 2'b10);
                if (ok && rem_reg == 2'd3)
                begin
                    // overlong four-byte form and values above 0x10ffff
                    if (part_reg == PART_W'(0) && in_byte < 8'h90)
                        ok = 1'b0;
                    if (part_reg == PART_W'(4) && in_byte >= 8'h90)
                        ok = 1'b0;
                    if (part_reg > PART_W'(4))
                        ok = 1'b0;
                end
                else if (ok && rem_reg == 2'd2 && part_reg < PART_W'(16))
                begin
                    // overlong three-byte form and surrogates
                    if (part_reg == PART_W'(0) && in_byte < 8'hA0)
                        ok = 1'b0;
                    if (part_reg == PART_W'(13) && in_byte >= 8'hA0)
                        ok = 1'b0;
                end
                if (!ok)
                begin
                    err = ERR_INVALID;
                end
                else
                begin
                    rem_next = rem_reg - 2'd1;
                    if (rem_reg == 2'd1)
                    begin
                        cp        = CP_W'({part_reg, in_byte[5:0]});
                        have_cp   = 1'b1;
                        part_next = '0;
                    end
                    else
                    begin
                        part_next = PART_W'({part_reg, in_byte[5:0]});
                    end
                end
            end

            if (err == ERR_NONE && have_cp)
            begin
                if (cp[CP_W-1:8] != '0)
                begin
                    has_out = 1'b1;
                    case (cp)
                        CP_W'(21'h160):  enc_data = 8'h8A;
                        CP_W'(21'h161):  enc_data = 8'h9A;
                        CP_W'(21'h17D):  enc_data = 8'h8E;
                        CP_W'(21'h17E):  enc_data = 8'h9E;
                        CP_W'(21'h20AC): enc_op   = OP_EURO;
                        default:
                        begin
                            has_out = 1'b0;
                            err     = ERR_UNSUPPORTED;
                        end
                    endcase
                end
                else
                begin
                    case (cp[7:0])
                        8'h28, 8'h29, 8'h5C:
                        begin
                            has_out  = 1'b1;
                            enc_op   = OP_ESC;
                            enc_data = cp[7:0];
                        end
                        // dropped controls
                        8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C:
                        begin
                            has_out = 1'b0;
                        end
                        default:
                        begin
                            has_out  = 1'b1;
                            enc_data = cp[7:0];
                        end
                    endcase
                end
            end

            // text ends in the middle of a sequence
            if (err == ERR_NONE && eot && rem_next != 2'd0)
                err = ERR_INVALID;

            if (err != ERR_NONE)
            begin
                push      = 1'b1;
                desc.err  = err;
                part_next = '0;
                rem_next  = '0;
                latch_next = !eot;
            end
            else if (!has_out)
            begin
                if (eot)
                begin
                    push      = 1'b1;
                    part_next = '0;
                    rem_next  = '0;
                end
            end
            else
            begin
                push      = 1'b1;
                desc.op   = enc_op;
                desc.data = enc_data;
                if (eot)
                begin
                    part_next = '0;
                    rem_next  = '0;
                end
            end
        end

        if (!accept)
            push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg  <= '0;
            rem_reg   <= '0;
            latch_reg <= 1'b0;
        end
        else if (accept)
        begin
            part_reg  <= part_next;
            rem_reg   <= rem_next;
            latch_reg <= latch_next;
        end
    end

`ifndef ASSERT_OFF
    // a latched error never leaves a sequence open
    a_latch_closed: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg |-> (rem_reg == 2'd0 && part_reg == '0))
        else $error("error latched with open sequence");
`endif

endmodule

/* hw/rtl/u8pdfesc_fifo.sv */
// small flop queue of decoded entries between decoder and expander
module u8pdfesc_fifo
    import u8pdfesc_pkg::*;
#(
    parameter int DEPTH = U8_FIFO_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  desc_t  wr_desc,
    input  logic   pop,
    output desc_t  rd_desc,
    output qstat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_desc    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_desc;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!stat.full || pop))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue read while empty");
`endif

endmodule

/* hw/rtl/u8pdfesc_back.sv */
// expander: queued entries into one result per cycle unless stalled
module u8pdfesc_back
    import u8pdfesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_t      head,
    input  qstat_t     stat,
    output logic       pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [3:0] m_axis_tuser,
    output logic       m_axis_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_idx;
    logic       emit;
    logic       is_last;
    logic [7:0] byte_val;

    logic       tvalid_reg, tvalid_next;
    logic [7:0] tdata_reg;
    logic [3:0] tuser_reg;
    logic       tlast_reg;

    always_comb
    begin
        case (head.op)
            OP_EURO: last_idx = 2'd3;
            OP_ESC:  last_idx = 2'd1;
            default: last_idx = 2'd0;
        endcase

        case (head.op)
            OP_EURO:
                byte_val = (idx_reg == 2'd0) ? CH_BSLASH :
                           (idx_reg == 2'd1) ? CH_TWO : CH_ZERO;
            OP_ESC:  byte_val = (idx_reg == 2'd0) ? CH_BSLASH : head.data;
            OP_BYTE: byte_val = head.data;
            default: byte_val = 8'h00;
        endcase
    end

    assign emit    = !stat.empty && (!tvalid_reg || m_axis_tready);
    assign is_last = (idx_reg == last_idx);
    assign pop     = emit && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        tvalid_next = tvalid_reg;
        if (emit)
            tvalid_next = 1'b1;
        else if (m_axis_tready)
            tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // payload: error_code, text_done, byte_valid from the top bit down
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            tdata_reg <= byte_val;
            tlast_reg <= is_last;
            tuser_reg <= {head.err, head.eot && is_last, head.op != OP_MARK};
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;
    assign m_axis_tlast  = tlast_reg;

`ifndef ASSERT_OFF
    // a result without a byte is always alone in its run
    a_mark_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("byte-less result not last of run");
    // errors never carry a byte
    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3:2] != ERR_NONE) |-> !m_axis_tuser[0])
        else $error("error result carries a byte");
    // text done only closes a run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("text done before end of run");
`endif

endmodule

/* hw/rtl/utf8_to_pdf_string_escaper.sv */
// top level of the utf-8 to pdf literal string escaper
//
//   channel  dir  tdata           tuser                                   tlast
//   s_axis   in   in_byte [7:0]   -                                       end_of_text
//   m_axis   out  out_byte [7:0]  [0] byte_valid [1] text_done [3:2] err  last_of_run
//
// one input byte is taken per cycle while the entry queue has room; the expander
// emits one result per cycle while m_axis is not stalled, so plain bytes sustain one
// per cycle, escaped brackets and backslash give two output results and the euro sign four
// an input transaction reaches its first result through the queue entry and then
// the output register
// reset clears the decoder state, the queue pointers and the output valid
// s_axis_tready drops only while the entry queue is full; a stalled m_axis
// fills the queue first
module utf8_to_pdf_string_escaper
    import u8pdfesc_pkg::*;
#(
    parameter int FIFO_DEPTH = U8_FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_text

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [0] byte_valid, [1] text_done, [3:2] error_code
    output logic       m_axis_tlast    // last_of_run
);

    logic   accept;
    logic   push;
    logic   pop;
    desc_t  wr_desc;
    desc_t  head;
    qstat_t stat;

    // every input transaction is decoded, even those that queue nothing
    assign s_axis_tready = !stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    u8pdfesc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .eot     (s_axis_tlast),
        .push    (push),
        .desc    (wr_desc)
    );

    u8pdfesc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .rd_desc (head),
        .stat    (stat)
    );

    u8pdfesc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .stat          (stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* verif/utf8_to_pdf_string_escaper_tb.sv */
// testbench for the utf-8 to pdf literal string escaper: directed table, random texts, scoreboard
module utf8_to_pdf_string_escaper_tb;
    import u8pdfesc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result of the escaper, as the master side carries it
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       done;
        err_t       err;
    } esc_result_t;

    // one row of the directed table; typed rows carry their own expectation,
    // the rest are checked against the escape predictor
    typedef struct packed {
        logic [7:0]  b;
        logic        eot;
        logic        typed;
        logic        has_res;
        esc_result_t res;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 290;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction on either side
    localparam int TAIL_CYCLES  = 10;     // margin after the last expected result

    // code points that the escaper escapes or drops, with nul and 0x7f as edge cases
    localparam logic [7:0] ASCII_SPECIALS [10] = '{
        8'h28, 8'h29, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C, 8'h00, 8'h7F
    };
    localparam logic [20:0] CP1252_SOURCES [4] = '{21'h160, 21'h161, 21'h17D, 21'h17E};

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // plain ascii, nul and the top of the 7-bit range pass through
        '{8'h41, 1'b0, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE}},
        '{8'h7F, 1'b0, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0, ERR_NONE}},
        // brackets and backslash get a backslash prefix
        '{8'h28, 1'b0, 1'b0, 1'b0, '0},
        '{8'h5C, 1'b0, 1'b0, 1'b0, '0},
        // newline dropped, carriage return at end of text leaves an empty marker
        '{8'h0A, 1'b0, 1'b1, 1'b0, '0},
        '{8'h0D, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE}},
        // s with caron maps to a single cp1252 byte
        '{8'hC5, 1'b0, 1'b1, 1'b0, '0},
        '{8'hA0, 1'b0, 1'b0, 1'b0, '0},
        // euro sign expands to four bytes
        '{8'hE2, 1'b0, 1'b1, 1'b0, '0},
        '{8'h82, 1'b0, 1'b1, 1'b0, '0},
        '{8'hAC, 1'b0, 1'b0, 1'b0, '0},
        // u+0100 is unsupported, the text is then ignored up to its end
        '{8'hC4, 1'b0, 1'b1, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_UNSUPPORTED}},
        '{8'h41, 1'b0, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE}},
        // bad lead byte, then end of text after the error
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_INVALID}},
        '{8'h80, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE}},
        // stray continuation byte that also ends the text
        '{8'h80, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_INVALID}},
        // surrogate half
        '{8'hED, 1'b0, 1'b1, 1'b0, '0},
        '{8'hA0, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_INVALID}},
        '{8'hF4, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE}},
        // text truncated inside a four-byte sequence
        '{8'hF4, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_INVALID}},
        // code point above u+10ffff
        '{8'hF4, 1'b0, 1'b1, 1'b0, '0},
        '{8'h90, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_INVALID}}
    };

    // all inputs known from time zero
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic       m_axis_tlast;

    // predictor state: decoder of the current text
    logic [20:0] cp_bits     = '0;
    logic [1:0]  cont_left   = '0;
    logic        text_failed = 1'b0;

    esc_result_t pending_pdf_bytes [$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [7:0]  stall_phase = '0;

    utf8_to_pdf_string_escaper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // end of text, or the end of an error, starts the next text from scratch
    function automatic void start_new_text();
        cp_bits     = '0;
        cont_left   = '0;
        text_failed = 1'b0;
    endfunction

    // escape predictor: feeds one utf-8 byte and returns the pdf string bytes it
    // releases, or a marker result for errors and the end of text
    function automatic int predict_escape(input logic [7:0] b, input logic eot,
                                          output esc_result_t res [4]);
        err_t        err;
        logic [20:0] cp;
        logic        have_cp;
        logic        ok;
        int          n;
        logic [7:0]  pdf [4];

        err     = ERR_NONE;
        cp      = '0;
        have_cp = 1'b0;
        n       = 0;
        foreach (res[k]) res[k] = '0;
        foreach (pdf[k]) pdf[k] = '0;

        // after an error only the end of text is seen, as a clean marker
        if (text_failed)
        begin
            if (!eot)
                return 0;
            res[0] = '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE};
            start_new_text();
            return 1;
        end

        if (cont_left == 2'd0)
        begin
            if (b < 8'h80)
            begin
                cp      = {13'd0, b};
                have_cp = 1'b1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                cp_bits   = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                cp_bits   = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                cp_bits   = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
            else
                err = ERR_INVALID;
        end
        else
        begin
            ok = (b[7:6] == 2'b10);
            // overlong four-byte forms and anything past u+10ffff
            if (ok && cont_left == 2'd3)
            begin
                if (cp_bits == 21'd0 && b < 8'h90) ok = 1'b0;
                if (cp_bits == 21'd4 && b >= 8'h90) ok = 1'b0;
                if (cp_bits > 21'd4) ok = 1'b0;
            end
            // overlong three-byte forms and surrogates
            else if (ok && cont_left == 2'd2 && cp_bits < 21'h10)
            begin
                if (cp_bits == 21'd0 && b < 8'hA0) ok = 1'b0;
                if (cp_bits == 21'hD && b >= 8'hA0) ok = 1'b0;
            end
            if (!ok)
                err = ERR_INVALID;
            else
            begin
                cp_bits   = {cp_bits[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    cp      = cp_bits;
                    have_cp = 1'b1;
                    cp_bits = '0;
                end
            end
        end

        if (err == ERR_NONE && have_cp)
        begin
            if (cp > 21'hFF)
            begin
                case (cp)
                    21'h160: begin pdf[0] = 8'h8A; n = 1; end
                    21'h161: begin pdf[0] = 8'h9A; n = 1; end
                    21'h17D: begin pdf[0] = 8'h8E; n = 1; end
                    21'h17E: begin pdf[0] = 8'h9E; n = 1; end
                    21'h20AC:
                    begin
                        pdf = '{CH_BSLASH, CH_TWO, CH_ZERO, CH_ZERO};
                        n   = 4;
                    end
                    default: err = ERR_UNSUPPORTED;
                endcase
            end
            else if (cp == 21'h28 || cp == 21'h29 || cp == 21'h5C)
            begin
                pdf[0] = CH_BSLASH;
                pdf[1] = cp[7:0];
                n      = 2;
            end
            else if (cp == 21'h0A || cp == 21'h0D || cp == 21'h09 || cp == 21'h08 ||
                     cp == 21'h0C)
                n = 0;
            else
            begin
                pdf[0] = cp[7:0];
                n      = 1;
            end
        end

        // end of text with a sequence still open
        if (err == ERR_NONE && eot && cont_left != 2'd0)
            err = ERR_INVALID;

        if (err != ERR_NONE)
        begin
            res[0] = '{8'h00, 1'b0, 1'b1, eot, err};
            if (eot)
                start_new_text();
            else
            begin
                text_failed = 1'b1;
                cp_bits     = '0;
                cont_left   = '0;
            end
            return 1;
        end

        if (n == 0)
        begin
            if (!eot)
                return 0;
            res[0] = '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE};
            start_new_text();
            return 1;
        end

        for (int k = 0; k < n; k++)
            res[k] = '{pdf[k], 1'b1, 1'b0, 1'b0, ERR_NONE};
        res[n-1].last = 1'b1;
        if (eot)
        begin
            res[n-1].done = 1'b1;
            start_new_text();
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        mismatches++;
    endtask

    // offer one byte on the slave side; the sender runs in bursts with random
    // gaps, and a gap of zero keeps tvalid high across transactions
    task automatic send_text_byte(input logic [7:0] b, input logic eot, input logic typed,
                                  input logic has_res, input esc_result_t typed_res);
        int          gap;
        int          n;
        esc_result_t res [4];

        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        burst_left--;
        items_sent++;

        // the predictor always runs so that its state follows the text
        n = predict_escape(b, eot, res);
        if (typed)
        begin
            if (has_res)
                pending_pdf_bytes.push_back(typed_res);
        end
        else
            for (int k = 0; k < n; k++)
                pending_pdf_bytes.push_back(res[k]);
    endtask

    // hold the sender off until every expected result has been taken
    task automatic drain_pending();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_pdf_bytes.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls: four patterns, switched in turn by the top bits of a free-running
    // phase counter, one of them never stalling
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 2) != 0);
            2'd2:    m_axis_tready <= (stall_phase[1:0] != 2'd3);
            default: m_axis_tready <= stall_phase[2] | ($urandom_range(0, 3) == 0);
        endcase
    end

    // scoreboard: each master transaction against the oldest expectation
    always @(posedge clk)
    begin : check_results
        esc_result_t got;
        esc_result_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
                    err_t'(m_axis_tuser[3:2])};
            if (pending_pdf_bytes.size() == 0)
                report_mismatch($sformatf("unexpected result byte=%02h tuser=%h tlast=%b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = pending_pdf_bytes.pop_front();
                if (got.valid !== want.valid)
                    report_mismatch($sformatf("byte_valid got %b want %b",
                                              got.valid, want.valid));
                if (got.data !== want.data)
                    report_mismatch($sformatf("out_byte got %02h want %02h",
                                              got.data, want.data));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_of_run got %b want %b",
                                              got.last, want.last));
                if (got.done !== want.done)
                    report_mismatch($sformatf("text_done got %b want %b",
                                              got.done, want.done));
                if (got.err !== want.err)
                    report_mismatch($sformatf("error_code got %0d want %0d",
                                              got.err, want.err));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  text_q [$];
        logic [20:0] cp;
        int          ncp;
        int          roll;
        int          start;
        logic        paused;

        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED_ROWS[i])
            send_text_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].eot, DIRECTED_ROWS[i].typed,
                           DIRECTED_ROWS[i].has_res, DIRECTED_ROWS[i].res);
        drain_pending();

        // random texts: mostly well-formed utf-8 with random code points, with
        // some noise bytes and cut-off sequences mixed in
        while (items_sent < $size(DIRECTED_ROWS) + RANDOM_ITEMS)
        begin
            text_q.delete();
            ncp = $urandom_range(1, 10);
            for (int c = 0; c < ncp; c++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                    continue;
                end
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    cp = 21'($urandom_range(8'h20, 8'h7E));
                else if (roll < 45)
                    cp = {13'd0, ASCII_SPECIALS[$urandom_range(0, 9)]};
                else if (roll < 55)
                    cp = 21'($urandom_range(0, 8'h7F));
                else if (roll < 65)
                    cp = 21'($urandom_range(8'h80, 8'hFF));
                else if (roll < 73)
                    cp = CP1252_SOURCES[$urandom_range(0, 3)];
                else if (roll < 79)
                    cp = 21'h20AC;
                else if (roll < 86)
                    cp = 21'($urandom_range(12'h100, 12'h7FF));
                else if (roll < 93)
                    cp = 21'($urandom_range(16'h800, 16'hFFFF));
                else
                    cp = 21'($urandom_range(32'h10000, 32'h10FFFF));

                start = text_q.size();
                if (cp < 21'h80)
                    text_q.push_back(cp[7:0]);
                else if (cp < 21'h800)
                begin
                    text_q.push_back({3'b110, cp[10:6]});
                    text_q.push_back({2'b10, cp[5:0]});
                end
                else if (cp < 21'h10000)
                begin
                    text_q.push_back({4'b1110, cp[15:12]});
                    text_q.push_back({2'b10, cp[11:6]});
                    text_q.push_back({2'b10, cp[5:0]});
                end
                else
                begin
                    text_q.push_back({5'b11110, cp[20:18]});
                    text_q.push_back({2'b10, cp[17:12]});
                    text_q.push_back({2'b10, cp[11:6]});
                    text_q.push_back({2'b10, cp[5:0]});
                end
                // now and then cut a multi-byte sequence short
                if (text_q.size() - start > 1 && $urandom_range(0, 19) == 0)
                    void'(text_q.pop_back());
            end

            foreach (text_q[i])
                send_text_byte(text_q[i], i == text_q.size() - 1, 1'b0, 1'b0, '0);

            // one pause in the middle until the escaper has emptied out
            if (!paused && items_sent >= $size(DIRECTED_ROWS) + RANDOM_ITEMS / 2)
            begin
                drain_pending();
                paused = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_pdf_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
